/* hdl/next_prime_search_defines.svh */
// ----------------------------------------------------------------------------
// next_prime_search assertion macros
// Shared concurrent assertion forms for the prime search checkers.
// ----------------------------------------------------------------------------
`ifndef NEXT_PRIME_SEARCH_DEFINES_SVH
`define NEXT_PRIME_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NPS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/nps_pkg.sv */
// ----------------------------------------------------------------------------
// nps_pkg
// Widths and state codes shared by the next prime search block.
// ----------------------------------------------------------------------------
package nps_pkg;

  // Start value width; candidates carry one extra bit for the doubled bound.
  localparam int WIDTH   = 32;
  localparam int PRIME_W = WIDTH + 1;
  // Trial divisors never exceed sqrt(2^PRIME_W) + 2.
  localparam int DIV_W   = (PRIME_W + 1) / 2 + 1;
  localparam int CNT_W   = $clog2(PRIME_W);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CAND = 3'b010,
    S_DIV  = 3'b100
  } state_e;

endpackage

/* hdl/next_prime_search.sv */
// ----------------------------------------------------------------------------
// next_prime_search
// Smallest prime in [start, 2*start) by trial division.
// ----------------------------------------------------------------------------
// A transaction starts when start is high while busy is low; start_value_i is
// sampled at that edge. The block then walks candidates upward from the start
// value and tests each by trial division with odd divisors 3, 5, 7, ... until
// a divisor hits or the divisor passes the square root (divisor > quotient).
// When done, done_o pulses for exactly one cycle with prime_value_o and
// found_o; the receiver cannot stall, so the result must be taken in that
// cycle (the values then hold until the next result). Start values 0 and 1
// have no prime in range: prime_value_o is 0 and found_o is 0. Latency is
// data dependent: each candidate is first screened (small or even values),
// and each odd divisor tried costs a full serial division, since the divider
// produces one quotient bit per cycle over the 33-bit candidate. A prime
// near 2^32 takes about 32768 divisors; composites usually drop out after
// a few divisors. busy stays high from acceptance until the cycle
// before done_o, and a new transaction may start in the same cycle that
// done_o shows.
// ----------------------------------------------------------------------------
module next_prime_search (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [nps_pkg::WIDTH-1:0]   start_value_i,
  output logic                        done_o,
  output logic [nps_pkg::PRIME_W-1:0] prime_value_o,
  output logic                        found_o
);

  nps_pkg::state_e state_q, state_d;

  logic [nps_pkg::PRIME_W-1:0] cand_q, cand_d;    // candidate under test
  logic [nps_pkg::PRIME_W-1:0] limit_q, limit_d;  // exclusive upper bound
  logic [nps_pkg::DIV_W-1:0]   dvs_q, dvs_d;      // current trial divisor
  logic [nps_pkg::PRIME_W-1:0] res_q, res_d;
  logic                        found_q, found_d;
  logic                        done_q, done_d;

  logic                        div_load;
  logic                        div_done;
  logic [nps_pkg::PRIME_W-1:0] div_quo;
  logic [nps_pkg::DIV_W-1:0]   div_rem;

  nps_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (div_load),
    .dividend_i (cand_q),
    .divisor_i  (dvs_d),
    .done_o     (div_done),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  always_comb begin
    state_d  = state_q;
    cand_d   = cand_q;
    limit_d  = limit_q;
    dvs_d    = dvs_q;
    res_d    = res_q;
    found_d  = found_q;
    done_d   = 1'b0;
    div_load = 1'b0;
    case (state_q)
      nps_pkg::S_IDLE: begin
        if (start) begin
          cand_d  = nps_pkg::PRIME_W'(start_value_i);
          limit_d = {start_value_i, 1'b0};  // one bit wider, never wraps
          state_d = nps_pkg::S_CAND;
        end
      end
      nps_pkg::S_CAND: begin
        if (cand_q >= limit_q) begin
          // range exhausted (only for start 0 or 1)
          res_d   = '0;
          found_d = 1'b0;
          done_d  = 1'b1;
          state_d = nps_pkg::S_IDLE;
        end else if (cand_q[nps_pkg::PRIME_W-1:1] == '0) begin
          cand_d = cand_q + nps_pkg::PRIME_W'(1);      // 0 and 1: not prime
        end else if (cand_q[nps_pkg::PRIME_W-1:2] == '0) begin
          res_d   = cand_q;                            // 2 and 3: prime
          found_d = 1'b1;
          done_d  = 1'b1;
          state_d = nps_pkg::S_IDLE;
        end else if (!cand_q[0]) begin
          cand_d = cand_q + nps_pkg::PRIME_W'(1);      // even, above 2
        end else begin
          dvs_d    = nps_pkg::DIV_W'(3);
          div_load = 1'b1;
          state_d  = nps_pkg::S_DIV;
        end
      end
      nps_pkg::S_DIV: begin
        if (div_done) begin
          if (div_quo < nps_pkg::PRIME_W'(dvs_q)) begin
            // divisor passed the square root: no factor exists
            res_d   = cand_q;
            found_d = 1'b1;
            done_d  = 1'b1;
            state_d = nps_pkg::S_IDLE;
          end else if (div_rem == '0) begin
            cand_d  = cand_q + nps_pkg::PRIME_W'(1);
            state_d = nps_pkg::S_CAND;
          end else begin
            dvs_d    = dvs_q + nps_pkg::DIV_W'(2);
            div_load = 1'b1;
          end
        end
      end
      default: begin
        state_d = nps_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nps_pkg::S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q  <= cand_d;
    limit_q <= limit_d;
    dvs_q   <= dvs_d;
    res_q   <= res_d;
    found_q <= found_d;
  end

  assign busy          = (state_q != nps_pkg::S_IDLE);
  assign done_o        = done_q;
  assign prime_value_o = res_q;
  assign found_o       = found_q;

endmodule

/* hdl/nps_divider.sv */
// ----------------------------------------------------------------------------
// nps_divider
// Bit-serial restoring divider: one quotient bit per clock cycle.
// ----------------------------------------------------------------------------
module nps_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  logic [nps_pkg::PRIME_W-1:0] dividend_i,
  input  logic [nps_pkg::DIV_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [nps_pkg::PRIME_W-1:0] quotient_o,
  output logic [nps_pkg::DIV_W-1:0]   remainder_o
);

  logic                        active_q, active_d;
  logic                        done_q, done_d;
  logic [nps_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [nps_pkg::PRIME_W-1:0] quo_q, quo_d;
  logic [nps_pkg::DIV_W-1:0]   rem_q, rem_d;
  logic [nps_pkg::DIV_W-1:0]   dvs_q, dvs_d;
  logic [nps_pkg::DIV_W:0]     rem_ext;
  logic [nps_pkg::DIV_W-1:0]   rem_sub;
  logic                        ge;

  // Dividend bits shift out the top, quotient bits shift in at the bottom.
  assign rem_ext = {rem_q, quo_q[nps_pkg::PRIME_W-1]};
  assign ge      = rem_ext >= {1'b0, dvs_q};
  // difference is below the divisor whenever it is used, so the low bits suffice
  assign rem_sub = rem_ext[nps_pkg::DIV_W-1:0] - dvs_q;

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    dvs_d    = dvs_q;
    if (load_i) begin
      active_d = 1'b1;
      cnt_d    = '0;
      quo_d    = dividend_i;
      rem_d    = '0;
      dvs_d    = divisor_i;
    end else if (active_q) begin
      quo_d = {quo_q[nps_pkg::PRIME_W-2:0], ge};
      rem_d = ge ? rem_sub : rem_ext[nps_pkg::DIV_W-1:0];
      cnt_d = cnt_q + nps_pkg::CNT_W'(1);
      if (cnt_q == nps_pkg::CNT_W'(nps_pkg::PRIME_W - 1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

/* hdl/nps_checker.sv */
// ----------------------------------------------------------------------------
// nps_checker
// Port-level checks on the next prime search transaction sequence.
// ----------------------------------------------------------------------------
`include "next_prime_search_defines.svh"

module nps_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        done_o,
  input logic [nps_pkg::PRIME_W-1:0] prime_value_o,
  input logic                        found_o
);

  // accepted transaction keeps the block busy next cycle
  `NPS_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "accept without busy")

  // busy only drops together with a result
  `NPS_ASSERT_SAME(a_fall_done, clk_i, rst_ni, $fell(busy), done_o, "busy fell without result")

  // one strobe per transaction, never back to back
  `NPS_ASSERT_NEXT(a_single_done, clk_i, rst_ni, done_o, !done_o, "repeated result strobe")

  // a miss always reports zero, a hit never does
  `NPS_ASSERT_SAME(a_miss_zero, clk_i, rst_ni, done_o,
    (found_o == (prime_value_o != '0)) && !busy, "bad result encoding")

endmodule

bind next_prime_search nps_checker u_nps_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .prime_value_o(prime_value_o),
  .found_o      (found_o)
);

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_prime_search testbench
// Drives start values through the start/busy handshake, predicts the smallest
// prime in [start, 2*start) by trial division and checks every done_o result.
// ----------------------------------------------------------------------------

// One expected result of a search.
typedef struct packed {
  logic [nps_pkg::PRIME_W-1:0] prime;
  logic                        found;
} prime_result_t;

// Scoreboard: predicts a result for each accepted start value, checks results
// in order against the oldest prediction.
class prime_scoreboard;
  prime_result_t pending_primes[$];
  int unsigned   mismatches;

  function new();
    mismatches = 0;
  endfunction

  // Walk candidates upward; a candidate is prime if no odd divisor up to its
  // square root divides it (2 and 3 handled by the screen).
  function prime_result_t search_prime(logic [nps_pkg::WIDTH-1:0] first);
    logic [63:0]   cand;
    logic [63:0]   bound;
    logic [63:0]   divisor;
    logic          composite;
    prime_result_t res;
    res   = '0;
    cand  = 64'(first);
    bound = cand << 1;
    while (cand < bound && !res.found) begin
      composite = (cand < 2) || (cand > 3 && !cand[0]);
      divisor   = 3;
      while (!composite && divisor * divisor <= cand) begin
        if (cand % divisor == 0) composite = 1'b1;
        divisor += 2;
      end
      if (!composite) begin
        res.prime = cand[nps_pkg::PRIME_W-1:0];
        res.found = 1'b1;
      end
      cand++;
    end
    return res;
  endfunction

  function void note_start(logic [nps_pkg::WIDTH-1:0] first);
    pending_primes.push_back(search_prime(first));
  endfunction

  function void check_result(logic [nps_pkg::PRIME_W-1:0] prime, logic found);
    prime_result_t exp_res;
    if (pending_primes.size() == 0) begin
      $display("%0t: unexpected result prime %0d found %0b", $time, prime, found);
      mismatches++;
      return;
    end
    exp_res = pending_primes.pop_front();
    if (prime !== exp_res.prime) begin
      $display("%0t: prime_value mismatch: expected %0d, actual %0d",
               $time, exp_res.prime, prime);
      mismatches++;
    end
    if (found !== exp_res.found) begin
      $display("%0t: found mismatch: expected %0b, actual %0b",
               $time, exp_res.found, found);
      mismatches++;
    end
  endfunction
endclass

module tb;

  localparam int W = nps_pkg::WIDTH;

  // The worst correct run is one search near 2^32 plus a tail of 24-bit
  // searches; the limit leaves a wide margin.
  localparam int unsigned CYCLE_LIMIT = 20_000_000;
  localparam int unsigned RANDOM_ITEMS = 122;
  // The last stretch of random items runs with no idle bursts.
  localparam int unsigned QUIET_TAIL = 30;
  localparam int unsigned DRAIN_CYCLES = 50;

  // Directed start values:
  //  - zero and one have no prime in range
  //  - two is itself prime; four must not be reported prime
  //  - prime squares (25, 49, 121) sit right on the square-root bound
  //  - 1328 starts inside a long prime gap (next prime 1361)
  //  - 65521 is the top 16-bit prime, 65536 crosses into 17 bits
  //  - all ones: slowest case, sets every upper bit of the field
  localparam int unsigned N_DIRECTED = 18;
  localparam logic [W-1:0] DIRECTED_STARTS [N_DIRECTED] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd8, 32'd9,
    32'd24, 32'd25, 32'd49, 32'd121, 32'd1328, 32'h0000_7fff,
    32'd65521, 32'd65536, 32'h00ff_ffff, 32'hffff_ffff
  };

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start;
  logic                        busy;
  logic [W-1:0]                start_value_i;
  logic                        done_o;
  logic [nps_pkg::PRIME_W-1:0] prime_value_o;
  logic                        found_o;

  prime_scoreboard sb;
  int unsigned     cycles;

  next_prime_search i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .start_value_i (start_value_i),
    .done_o        (done_o),
    .prime_value_o (prime_value_o),
    .found_o       (found_o)
  );

  // 20 ns clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Cycle counter and watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[next_prime_search] ERROR");
      $finish;
    end
  end

  // Monitor: a transaction is taken on start && !busy; results are valid for
  // the single cycle done_o is high and cannot be held off. Values read here
  // are the ones from before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_start(start_value_i);
      if (done_o) sb.check_result(prime_value_o, found_o);
    end
  end

  // Mostly short searches (<= 16 bits), a few tiny ones to hit 0/1/2 often,
  // and an occasional 17..24 bit start to exercise longer divisor runs.
  function automatic logic [W-1:0] pick_start();
    int unsigned nbits;
    case ($urandom_range(0, 19))
      0:       nbits = $urandom_range(17, 24);
      1, 2:    nbits = $urandom_range(0, 4);
      default: nbits = $urandom_range(5, 16);
    endcase
    return W'($urandom & ((64'd1 << nbits) - 1));
  endfunction

  // Offer one start value and hold it until it is taken. Called at a falling
  // edge, returns at the falling edge after acceptance with start still high,
  // so back-to-back transactions keep start asserted across the busy period.
  task automatic issue_search(input logic [W-1:0] first, input bit allow_idle);
    int unsigned gap;
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start         <= 1'b1;
    start_value_i <= first;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    sb            = new();
    cycles        = 0;
    rst_ni        = 1'b0;
    start         = 1'b0;
    start_value_i = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++) issue_search(DIRECTED_STARTS[i], 1'b1);

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++)
      issue_search(pick_start(), n < RANDOM_ITEMS - QUIET_TAIL);
    start <= 1'b0;

    // Drain: one result per transaction, then a short settle window.
    while (sb.pending_primes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.mismatches == 0) begin
      $display("[next_prime_search] OK");
    end else begin
      $display("[next_prime_search] ERROR");
    end
    $finish;
  end

endmodule
